// ===== src/rsbv_pkg.sv =====
// Shared constants, codes and popcount functions for the rank/select bit vector.
`timescale 1ns / 1ps
`default_nettype none
package rsbv_pkg;

    localparam int MAX_BITS_DEF   = 65536;
    localparam int WPL_DEF        = 8;
    localparam int WORD_BITS      = 64;
    localparam int LEN_W          = 7;
    localparam int OP_W           = 3;
    localparam int CMD_FIFO_DEPTH = 4;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_RANK   = 2'd2;
    localparam logic [1:0] MODE_SELECT = 2'd3;

    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_READ   = 3'd1;
    localparam logic [OP_W-1:0] OP_RANK   = 3'd2;
    localparam logic [OP_W-1:0] OP_SELECT = 3'd3;
    localparam logic [OP_W-1:0] OP_REJECT = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [63:0] POP_M1 = 64'h5555555555555555;
    localparam logic [63:0] POP_M2 = 64'h3333333333333333;
    localparam logic [63:0] POP_M4 = 64'h0f0f0f0f0f0f0f0f;

    function automatic logic [6:0] pop64(input logic [63:0] r);
        logic [63:0] t;
        t = (r & POP_M1) + ((r >> 1) & POP_M1);
        t = (t & POP_M2) + ((t >> 2) & POP_M2);
        t = (t + (t >> 4)) & POP_M4;
        t = t + (t >> 8);
        t = t + (t >> 16);
        t = t + (t >> 32);
        return t[6:0];
    endfunction

    function automatic logic [3:0] pop8(input logic [7:0] b);
        logic [3:0] c;
        c = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            c = c + 4'(b[i]);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== src/rank_select_bit_vector.sv =====
// Top level of the rank/select bit vector: front, command queue and back.
//
//  Channel  | Handshake            | Fields
//  ---------+----------------------+--------------------------------------------------
//  input    | push / full          | mode, position, bit_kind, append_word, append_length
//  result   | empty / pop          | answer, status
//
// An append writes its word, and the next word too when it spills over; a read fetches
// one word. Rank runs a binary search over the block counts and then scans words on the
// one read port of the word memory; select also narrows the last word byte by byte.
// Reset empties the vector at once; no clearing pass runs.
// Up to four words queue ahead of the back end while a result waits to be popped.
`timescale 1ns / 1ps
`default_nettype none
module rank_select_bit_vector import rsbv_pkg::*; #(
    parameter int MAX_BITS              = MAX_BITS_DEF,
    parameter int WORDS_PER_LARGE_BLOCK = WPL_DEF,
    localparam int POS_W = $clog2(MAX_BITS + 1),
    localparam int CMD_W = OP_W + 1 + POS_W + WORD_BITS + LEN_W
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [1:0]           mode,
    input  wire logic [POS_W-1:0]     position,
    input  wire logic                 bit_kind,
    input  wire logic [WORD_BITS-1:0] append_word,
    input  wire logic [LEN_W-1:0]     append_length,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [POS_W-1:0]          answer,
    output logic [1:0]                status
);

    logic             fifo_full, fifo_wr, fifo_rd, fifo_valid;
    logic [CMD_W-1:0] cmd_in, cmd_out;

    rsbv_front #(.POS_W(POS_W)) u_front (
        .push          (push),
        .full          (full),
        .mode          (mode),
        .position      (position),
        .bit_kind      (bit_kind),
        .append_word   (append_word),
        .append_length (append_length),
        .fifo_full     (fifo_full),
        .fifo_wr       (fifo_wr),
        .cmd           (cmd_in)
    );

    rsbv_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_FIFO_DEPTH)) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (fifo_wr),
        .wr_data  (cmd_in),
        .full     (fifo_full),
        .rd_en    (fifo_rd),
        .rd_data  (cmd_out),
        .rd_valid (fifo_valid)
    );

    rsbv_back #(
        .MAX_BITS (MAX_BITS),
        .WPL      (WORDS_PER_LARGE_BLOCK),
        .POS_W    (POS_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (fifo_valid),
        .cmd       (cmd_out),
        .cmd_rd    (fifo_rd),
        .empty     (empty),
        .pop       (pop),
        .answer    (answer),
        .status    (status)
    );

endmodule
`default_nettype wire

// ===== src/rsbv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rsbv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== src/rsbv_fifo.sv =====
// Short command queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module rsbv_fifo #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  rd_valid
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (wr_en)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// ===== src/rsbv_front.sv =====
// Front end: accepts input words, classifies them and masks append data.
`timescale 1ns / 1ps
`default_nettype none
module rsbv_front import rsbv_pkg::*; #(
    parameter int POS_W = 17,
    localparam int CMD_W = OP_W + 1 + POS_W + WORD_BITS + LEN_W
) (
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [1:0]           mode,
    input  wire logic [POS_W-1:0]     position,
    input  wire logic                 bit_kind,
    input  wire logic [WORD_BITS-1:0] append_word,
    input  wire logic [LEN_W-1:0]     append_length,
    input  wire logic                 fifo_full,
    output logic                      fifo_wr,
    output logic [CMD_W-1:0]          cmd
);

    logic [OP_W-1:0]      op;
    logic [WORD_BITS-1:0] masked;

    assign full    = fifo_full;
    assign fifo_wr = push && !fifo_full;

    always_comb
    begin
        case (mode)
            MODE_APPEND:
            begin
                op = (append_length == '0 || append_length > LEN_W'(WORD_BITS))
                     ? OP_REJECT : OP_APPEND;
            end
            MODE_READ:   op = OP_READ;
            MODE_RANK:   op = OP_RANK;
            MODE_SELECT: op = (position == '0) ? OP_REJECT : OP_SELECT;
            default:     op = OP_REJECT;
        endcase
        // A length of 64 has bit 6 set and keeps the whole word.
        masked = append_length[6] ? append_word
               : (append_word & ~({WORD_BITS{1'b1}} << append_length[5:0]));
    end

    assign cmd = {op, bit_kind, position, masked, append_length};

endmodule
`default_nettype wire

// ===== src/rsbv_back.sv =====
// Back end: bit storage, block counts and the append/read/rank/select sequencer.
`timescale 1ns / 1ps
`default_nettype none
module rsbv_back import rsbv_pkg::*; #(
    parameter int MAX_BITS = MAX_BITS_DEF,
    parameter int WPL      = WPL_DEF,
    parameter int POS_W    = 17,
    localparam int CMD_W   = OP_W + 1 + POS_W + WORD_BITS + LEN_W
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    input  wire logic [CMD_W-1:0] cmd,
    output logic                  cmd_rd,
    output logic                  empty,
    input  wire logic             pop,
    output logic [POS_W-1:0]      answer,
    output logic [1:0]            status
);

    localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int NUM_LARGE = (NUM_WORDS + WPL - 1) / WPL;
    localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BLK_W     = (NUM_LARGE > 1) ? $clog2(NUM_LARGE) : 1;
    localparam int NBLK_W    = $clog2(NUM_LARGE + 1);
    localparam int NBW_W     = $clog2(NUM_LARGE * WPL + 1);
    localparam int KW        = (BLK_W > 1) ? $clog2(BLK_W) : 1;
    localparam int WI_W      = (WPL > 1) ? $clog2(WPL) : 1;
    localparam int XW        = POS_W + BLK_W + 8;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DISPATCH   = 4'd1;
    localparam logic [3:0] S_SRCH_ISSUE = 4'd2;
    localparam logic [3:0] S_SRCH_EVAL  = 4'd3;
    localparam logic [3:0] S_BLK_ISSUE  = 4'd4;
    localparam logic [3:0] S_BLK_EVAL   = 4'd5;
    localparam logic [3:0] S_WORD_ISSUE = 4'd6;
    localparam logic [3:0] S_WORD_EVAL  = 4'd7;
    localparam logic [3:0] S_NARROW     = 4'd8;
    localparam logic [3:0] S_APP_LO     = 4'd9;
    localparam logic [3:0] S_APP_HI     = 4'd10;

    logic [3:0]           state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic                 kind_reg, kind_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [WORD_BITS-1:0] x_reg, x_next;
    logic [LEN_W-1:0]     alen_reg, alen_next;
    logic [POS_W-1:0]     len_reg, len_next;
    logic [POS_W-1:0]     total_reg, total_next;
    logic [WORD_BITS-1:0] tail_reg, tail_next;
    logic [NBLK_W-1:0]    nblk_reg, nblk_next;
    logic [NBW_W-1:0]     nbw_reg, nbw_next;
    logic [BLK_W-1:0]     lo_reg, lo_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [POS_W-1:0]     acc_reg, acc_next;
    logic [WIDX_W-1:0]    wcur_reg, wcur_next;
    logic [WI_W-1:0]      wi_reg, wi_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [2:0]           byte_reg, byte_next;
    logic [POS_W-1:0]     ans_reg, ans_next;
    logic [1:0]           st_reg, st_next;
    logic                 oval_reg, oval_next;

    logic                 wd_we, cm_we;
    logic [WIDX_W-1:0]    wd_waddr;
    logic [WORD_BITS-1:0] wd_wdata, wd_rdata;
    logic [BLK_W-1:0]     cm_waddr, cm_raddr;
    logic [POS_W-1:0]     cm_wdata, cm_rdata;

    logic [POS_W-1:0]     pos_sh, len_sh;
    logic [WIDX_W-1:0]    wtgt, app_w;
    logic [5:0]           off;
    logic [BLK_W-1:0]     cand, blk_idx;
    logic                 cand_lt;
    logic [XW-1:0]        blk_base, prior_cnt, rem_bits;
    logic [6:0]           vcnt, pop_w, pop_a, c_word;
    logic [WORD_BITS-1:0] rank_mask, lo_bits, new_lo;
    logic [7:0]           app_sum;
    logic [POS_W-1:0]     ones, total_k;
    logic [7:0]           cur_byte, byte_k;
    logic [3:0]           c8, run;
    logic [2:0]           idx;

    rsbv_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_WORDS)) u_words (
        .clk   (clk),
        .we    (wd_we),
        .waddr (wd_waddr),
        .wdata (wd_wdata),
        .raddr (wcur_reg),
        .rdata (wd_rdata)
    );

    // Entry b holds the number of ones stored before large block b.
    rsbv_ram #(.WIDTH(POS_W), .DEPTH(NUM_LARGE)) u_cum (
        .clk   (clk),
        .we    (cm_we),
        .waddr (cm_waddr),
        .wdata (cm_wdata),
        .raddr (cm_raddr),
        .rdata (cm_rdata)
    );

    assign empty  = !oval_reg;
    assign answer = ans_reg;
    assign status = st_reg;

    always_comb
    begin
        pos_sh    = pos_reg >> 6;
        len_sh    = len_reg >> 6;
        wtgt      = pos_sh[WIDX_W-1:0];
        app_w     = len_sh[WIDX_W-1:0];
        off       = len_reg[5:0];
        cand      = lo_reg | (BLK_W'(1) << k_reg);
        cand_lt   = (XW'(cand) < XW'(nblk_reg));
        blk_idx   = (state_reg == S_SRCH_EVAL) ? cand : lo_reg;
        cm_raddr  = (state_reg == S_SRCH_ISSUE) ? cand : lo_reg;
        blk_base  = (XW'(blk_idx) * XW'(WPL)) << 6;
        prior_cnt = kind_reg ? XW'(cm_rdata) : blk_base - XW'(cm_rdata);
        rem_bits  = XW'(len_reg) - (XW'(wcur_reg) << 6);
        vcnt      = (rem_bits >= XW'(WORD_BITS)) ? 7'(WORD_BITS) : rem_bits[6:0];
        rank_mask = {WORD_BITS{1'b1}} >> (6'd63 - pos_reg[5:0]);
        pop_w     = pop64((op_reg == OP_RANK && wcur_reg == wtgt)
                          ? (wd_rdata & rank_mask) : wd_rdata);
        c_word    = kind_reg ? pop_w : vcnt - pop_w;
        lo_bits   = x_reg << off;
        new_lo    = tail_reg | lo_bits;
        pop_a     = pop64((state_reg == S_APP_LO) ? lo_bits : word_reg);
        app_sum   = 8'(off) + 8'(alen_reg);
        ones      = acc_reg + POS_W'(pop_w);
        total_k   = kind_reg ? total_reg : len_reg - total_reg;
        cur_byte  = word_reg[{byte_reg, 3'b000} +: 8];
        byte_k    = kind_reg ? cur_byte : ~cur_byte;
        c8        = pop8(byte_k);
        run       = 4'd0;
        idx       = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (byte_k[i])
            begin
                run = run + 4'd1;
                if (POS_W'(run) == acc_reg)
                begin
                    idx = 3'(i);
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        kind_next  = kind_reg;
        pos_next   = pos_reg;
        x_next     = x_reg;
        alen_next  = alen_reg;
        len_next   = len_reg;
        total_next = total_reg;
        tail_next  = tail_reg;
        nblk_next  = nblk_reg;
        nbw_next   = nbw_reg;
        lo_next    = lo_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        wcur_next  = wcur_reg;
        wi_next    = wi_reg;
        word_next  = word_reg;
        byte_next  = byte_reg;
        ans_next   = ans_reg;
        st_next    = st_reg;
        oval_next  = oval_reg && !pop;
        cmd_rd     = 1'b0;
        wd_we      = 1'b0;
        wd_waddr   = app_w;
        wd_wdata   = new_lo;
        cm_we      = 1'b0;
        cm_waddr   = nblk_reg[BLK_W-1:0];
        cm_wdata   = total_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && !oval_reg)
                begin
                    cmd_rd = 1'b1;
                    {op_next, kind_next, pos_next, x_next, alen_next} = cmd;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (op_reg)
                    OP_APPEND:
                    begin
                        if ((XW'(len_reg) + XW'(alen_reg)) > XW'(MAX_BITS))
                        begin
                            ans_next   = '0;
                            st_next    = ST_FULL;
                            oval_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_APP_LO;
                        end
                    end
                    OP_READ, OP_RANK:
                    begin
                        if (pos_reg >= len_reg)
                        begin
                            ans_next   = '0;
                            st_next    = ST_BAD;
                            oval_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else if (op_reg == OP_READ)
                        begin
                            wcur_next  = wtgt;
                            state_next = S_WORD_ISSUE;
                        end
                        else
                        begin
                            lo_next    = '0;
                            k_next     = KW'(BLK_W - 1);
                            acc_next   = '0;
                            state_next = S_SRCH_ISSUE;
                        end
                    end
                    OP_SELECT:
                    begin
                        if (pos_reg > total_k)
                        begin
                            ans_next   = '0;
                            st_next    = ST_BAD;
                            oval_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            lo_next    = '0;
                            k_next     = KW'(BLK_W - 1);
                            acc_next   = pos_reg;
                            state_next = S_SRCH_ISSUE;
                        end
                    end
                    default:
                    begin
                        ans_next   = '0;
                        st_next    = ST_BAD;
                        oval_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SRCH_ISSUE:
            begin
                state_next = S_SRCH_EVAL;
            end
            S_SRCH_EVAL:
            begin
                // Rank looks for the block holding the word; select for the
                // last block whose preceding count is still below the target.
                if (cand_lt && ((op_reg == OP_RANK)
                                ? ((XW'(cand) * XW'(WPL)) <= XW'(wtgt))
                                : (prior_cnt < XW'(acc_reg))))
                begin
                    lo_next = cand;
                end
                if (k_reg == '0)
                begin
                    state_next = S_BLK_ISSUE;
                end
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = S_SRCH_ISSUE;
                end
            end
            S_BLK_ISSUE:
            begin
                state_next = S_BLK_EVAL;
            end
            S_BLK_EVAL:
            begin
                acc_next   = (op_reg == OP_RANK) ? cm_rdata : acc_reg - POS_W'(prior_cnt);
                wcur_next  = WIDX_W'(XW'(lo_reg) * XW'(WPL));
                wi_next    = '0;
                state_next = S_WORD_ISSUE;
            end
            S_WORD_ISSUE:
            begin
                state_next = S_WORD_EVAL;
            end
            S_WORD_EVAL:
            begin
                case (op_reg)
                    OP_READ:
                    begin
                        ans_next   = POS_W'(wd_rdata[pos_reg[5:0]]);
                        st_next    = ST_OK;
                        oval_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    OP_RANK:
                    begin
                        if (wcur_reg == wtgt)
                        begin
                            ans_next   = kind_reg ? ones : pos_reg + 1'b1 - ones;
                            st_next    = ST_OK;
                            oval_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            acc_next   = ones;
                            wcur_next  = wcur_reg + 1'b1;
                            state_next = S_WORD_ISSUE;
                        end
                    end
                    default:
                    begin
                        if (acc_reg <= POS_W'(c_word) || wi_reg == WI_W'(WPL - 1)
                            || wcur_reg == WIDX_W'(NUM_WORDS - 1))
                        begin
                            word_next  = wd_rdata;
                            byte_next  = 3'd0;
                            state_next = S_NARROW;
                        end
                        else
                        begin
                            acc_next   = acc_reg - POS_W'(c_word);
                            wcur_next  = wcur_reg + 1'b1;
                            wi_next    = wi_reg + 1'b1;
                            state_next = S_WORD_ISSUE;
                        end
                    end
                endcase
            end
            S_NARROW:
            begin
                if (acc_reg <= POS_W'(c8))
                begin
                    ans_next   = POS_W'({wcur_reg, byte_reg, idx});
                    st_next    = ST_OK;
                    oval_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (byte_reg == 3'd7)
                begin
                    ans_next   = '0;
                    st_next    = ST_BAD;
                    oval_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    acc_next  = acc_reg - POS_W'(c8);
                    byte_next = byte_reg + 1'b1;
                end
            end
            S_APP_LO:
            begin
                wd_we      = 1'b1;
                total_next = total_reg + POS_W'(pop_a);
                // The first word written into a new large block opens its count.
                if (NBW_W'(app_w) == nbw_reg)
                begin
                    cm_we     = 1'b1;
                    nblk_next = nblk_reg + 1'b1;
                    nbw_next  = nbw_reg + NBW_W'(WPL);
                end
                if (app_sum > 8'(WORD_BITS))
                begin
                    word_next  = x_reg >> (7'(WORD_BITS) - 7'(off));
                    state_next = S_APP_HI;
                end
                else
                begin
                    tail_next  = (app_sum == 8'(WORD_BITS)) ? '0 : new_lo;
                    len_next   = len_reg + POS_W'(alen_reg);
                    ans_next   = len_reg + POS_W'(alen_reg);
                    st_next    = ST_OK;
                    oval_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_APP_HI:
            begin
                wd_we      = 1'b1;
                wd_waddr   = app_w + 1'b1;
                wd_wdata   = word_reg;
                total_next = total_reg + POS_W'(pop_a);
                if (NBW_W'(app_w) + 1'b1 == nbw_reg)
                begin
                    cm_we     = 1'b1;
                    nblk_next = nblk_reg + 1'b1;
                    nbw_next  = nbw_reg + NBW_W'(WPL);
                end
                tail_next  = word_reg;
                len_next   = len_reg + POS_W'(alen_reg);
                ans_next   = len_reg + POS_W'(alen_reg);
                st_next    = ST_OK;
                oval_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            total_reg <= '0;
            tail_reg  <= '0;
            nblk_reg  <= '0;
            nbw_reg   <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            total_reg <= total_next;
            tail_reg  <= tail_next;
            nblk_reg  <= nblk_next;
            nbw_reg   <= nbw_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        kind_reg <= kind_next;
        pos_reg  <= pos_next;
        x_reg    <= x_next;
        alen_reg <= alen_next;
        lo_reg   <= lo_next;
        k_reg    <= k_next;
        acc_reg  <= acc_next;
        wcur_reg <= wcur_next;
        wi_reg   <= wi_next;
        word_reg <= word_next;
        byte_reg <= byte_next;
        ans_reg  <= ans_next;
        st_reg   <= st_next;
    end

endmodule
`default_nettype wire

// ===== src/rsbv_checker.sv =====
// Port-level checks for the rank/select bit vector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rsbv_checker import rsbv_pkg::*; #(
    parameter int POS_W = 17
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             full,
    input wire logic             empty,
    input wire logic             pop,
    input wire logic [POS_W-1:0] answer,
    input wire logic [1:0]       status
);

    // Reset leaves no result waiting and room in the queue.
    a_reset_clear: assert property (@(posedge clk) !rst_n |=> empty && !full)
        else $error("result or full flag present during reset");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status == ST_OK || status == ST_BAD || status == ST_FULL))
        else $error("undefined status code");

    // Every failed word reports a zero answer.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && status != ST_OK |-> answer == '0)
        else $error("nonzero answer with error status");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(answer) && $stable(status))
        else $error("waiting result changed");

endmodule

bind rank_select_bit_vector rsbv_checker #(.POS_W(POS_W)) u_rsbv_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .answer (answer),
    .status (status)
);
`default_nettype wire

// ===== tb/rank_select_bit_vector_test.sv =====
// Self-checking testbench for the rank/select bit vector with a queue handshake on both sides.
`timescale 1ns / 1ps
module rank_select_bit_vector_test;
    import rsbv_pkg::*;

    localparam int VEC_BITS  = 65536;
    localparam int VEC_WORDS = VEC_BITS / 64;
    localparam int HOLD_CYCLES = 300;
    localparam int STUCK_LIMIT = 5000;

    typedef struct {
        logic [16:0] answer;
        logic [1:0]  status;
    } answer_t;

    typedef struct {
        logic [1:0]  md;
        logic [16:0] pos;
        logic        kd;
        logic [63:0] wd;
        logic [6:0]  ln;
        bit          typed;
        logic [16:0] ans;
        logic [1:0]  st;
    } step_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  mode;
    logic [16:0] position;
    logic        bit_kind;
    logic [63:0] append_word;
    logic [6:0]  append_length;
    logic        empty;
    logic        pop;
    logic [16:0] answer;
    logic [1:0]  status;

    rank_select_bit_vector DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .mode(mode),
        .position(position), .bit_kind(bit_kind), .append_word(append_word),
        .append_length(append_length), .empty(empty), .pop(pop),
        .answer(answer), .status(status)
    );

    // Mirror of the stored vector.
    logic [63:0] vec_words [VEC_WORDS];
    int          vec_len;
    int          vec_ones;

    answer_t answers_due [$];
    step_t   script [25];
    int      errors;
    int      send_pct;
    int      stall_pct;
    bit      hold_req;
    int      hold_cnt;
    int      stuck_cycles;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic compute_answer(input logic [1:0] md, input logic [16:0] pos,
                                  input logic kd, input logic [63:0] wd,
                                  input logic [6:0] ln, output answer_t r);
        int w;
        int off;
        int cnt;
        int total;
        int rem;
        int valid;
        logic [63:0]  x;
        logic [127:0] sh;
        r.answer = '0;
        r.status = ST_OK;
        case (md)
            MODE_APPEND:
            begin
                if (ln == 0 || ln > 64)
                    r.status = ST_BAD;
                else if (vec_len + ln > VEC_BITS)
                    r.status = ST_FULL;
                else
                begin
                    x = (ln == 64) ? wd : (wd & ((64'd1 << ln) - 64'd1));
                    w = vec_len / 64;
                    off = vec_len % 64;
                    sh = {64'd0, x} << off;
                    vec_words[w] = vec_words[w] | sh[63:0];
                    if (w + 1 < VEC_WORDS)
                        vec_words[w + 1] = vec_words[w + 1] | sh[127:64];
                    vec_len = vec_len + ln;
                    vec_ones = vec_ones + $countones(x);
                    r.answer = 17'(vec_len);
                end
            end
            MODE_READ:
            begin
                if (pos >= vec_len)
                    r.status = ST_BAD;
                else
                    r.answer = 17'(vec_words[pos / 64][pos % 64]);
            end
            MODE_RANK:
            begin
                if (pos >= vec_len)
                    r.status = ST_BAD;
                else
                begin
                    w = pos / 64;
                    off = pos % 64;
                    cnt = 0;
                    for (int i = 0; i < w; i++)
                        cnt += $countones(vec_words[i]);
                    cnt += $countones(vec_words[w] & ({64{1'b1}} >> (63 - off)));
                    r.answer = kd ? 17'(cnt) : 17'(pos + 1 - cnt);
                end
            end
            default:
            begin
                total = kd ? vec_ones : vec_len - vec_ones;
                if (pos == 0 || pos > total)
                    r.status = ST_BAD;
                else
                begin
                    rem = pos;
                    for (w = 0; w < VEC_WORDS; w++)
                    begin
                        valid = vec_len - w * 64;
                        if (valid > 64)
                            valid = 64;
                        cnt = kd ? $countones(vec_words[w])
                                 : valid - $countones(vec_words[w]);
                        if (rem <= cnt)
                            break;
                        rem -= cnt;
                    end
                    for (int i = 0; i < 64; i++)
                    begin
                        if (vec_words[w][i] == kd)
                        begin
                            rem--;
                            if (rem == 0)
                            begin
                                r.answer = 17'(w * 64 + i);
                                break;
                            end
                        end
                    end
                end
            end
        endcase
    endtask

    // Offers one word and waits for it to be taken; returns at a falling edge.
    task automatic send_word(input step_t s);
        answer_t r;
        while ($urandom_range(99) < send_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        mode <= s.md;
        position <= s.pos;
        bit_kind <= s.kd;
        append_word <= s.wd;
        append_length <= s.ln;
        do
            @(posedge clk);
        while (full);
        compute_answer(s.md, s.pos, s.kd, s.wd, s.ln, r);
        if (s.typed)
        begin
            r.answer = s.ans;
            r.status = s.st;
        end
        answers_due = {answers_due, r};
        @(negedge clk);
    endtask

    function automatic step_t random_step();
        step_t s;
        int total;
        s.typed = 1'b0;
        s.ans = '0;
        s.st = ST_OK;
        s.kd = 1'($urandom);
        s.wd = {$urandom, $urandom};
        s.pos = 17'($urandom);
        s.ln = 7'($urandom);
        if ($urandom_range(99) < 65)
        begin
            s.md = MODE_APPEND;
            case ($urandom_range(19))
                0: s.ln = ($urandom_range(1) != 0) ? 7'd0 : 7'($urandom_range(127, 65));
                1, 2, 3: s.ln = 7'($urandom_range(63, 1));
                default: s.ln = 7'd64;
            endcase
        end
        else
        begin
            s.md = 2'($urandom_range(3, 1));
            if ($urandom_range(99) < 85)
            begin
                if (s.md == MODE_SELECT)
                begin
                    total = s.kd ? vec_ones : vec_len - vec_ones;
                    if (total > 0)
                        s.pos = 17'($urandom_range(total, 1));
                end
                else if (vec_len > 0)
                    s.pos = 17'($urandom_range(vec_len - 1, 0));
            end
        end
        return s;
    endfunction

    // Result side: random stalls, and a long hold-off on request.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cnt > 0)
            begin
                pop <= 1'b0;
                hold_cnt <= hold_cnt - 1;
            end
            else if (hold_req)
            begin
                pop <= 1'b0;
                hold_cnt <= HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (answers_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word: answer=%0d status=%0d", answer, status);
                end
                else
                begin
                    e = answers_due.pop_front();
                    if (answer !== e.answer || status !== e.status)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"word mismatch: expected answer=%0d status=%0d, ",
                                      "got answer=%0d status=%0d"},
                                     e.answer, e.status, answer, status);
                    end
                end
            end
            if ((pop && !empty) || (push && !full))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("rank_select_bit_vector: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        step_t s;
        int n;
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        mode = MODE_APPEND;
        position = '0;
        bit_kind = 1'b0;
        append_word = '0;
        append_length = 7'd1;
        errors = 0;
        send_pct = 0;
        stall_pct = 0;
        hold_req = 1'b0;
        hold_cnt = 0;
        stuck_cycles = 0;
        vec_len = 0;
        vec_ones = 0;
        for (int i = 0; i < VEC_WORDS; i++)
            vec_words[i] = '0;

        // Rows marked typed carry an answer read off directly; the rest use the mirror.
        script[0]  = '{MODE_READ,   17'd0,      1'b0, 64'd0, 7'd1, 1'b1, 17'd0, ST_BAD};
        script[1]  = '{MODE_RANK,   17'd0,      1'b1, 64'd0, 7'd1, 1'b1, 17'd0, ST_BAD};
        script[2]  = '{MODE_SELECT, 17'd1,      1'b1, 64'd0, 7'd1, 1'b1, 17'd0, ST_BAD};
        script[3]  = '{MODE_SELECT, 17'd0,      1'b0, 64'd0, 7'd1, 1'b1, 17'd0, ST_BAD};
        script[4]  = '{MODE_APPEND, 17'd0,      1'b0, {64{1'b1}}, 7'd0, 1'b1, 17'd0, ST_BAD};
        script[5]  = '{MODE_APPEND, 17'd0,      1'b0, {64{1'b1}}, 7'd65, 1'b1, 17'd0, ST_BAD};
        script[6]  = '{MODE_APPEND, 17'h1ffff,  1'b1, {64{1'b1}}, 7'd127, 1'b1, 17'd0, ST_BAD};
        script[7]  = '{MODE_APPEND, 17'd0,      1'b0, {64{1'b1}}, 7'd64, 1'b1, 17'd64, ST_OK};
        script[8]  = '{MODE_APPEND, 17'd0,      1'b0, 64'd0, 7'd1, 1'b1, 17'd65, ST_OK};
        script[9]  = '{MODE_APPEND, 17'd0,      1'b0, {64{1'b1}}, 7'd1, 1'b1, 17'd66, ST_OK};
        script[10] = '{MODE_APPEND, 17'd0,      1'b0, {64{1'b1}}, 7'd3, 1'b1, 17'd69, ST_OK};
        script[11] = '{MODE_APPEND, 17'd0,      1'b0, 64'd0, 7'd64, 1'b1, 17'd133, ST_OK};
        script[12] = '{MODE_APPEND, 17'd0,      1'b0, 64'haaaaaaaaaaaaaaaa, 7'd64, 1'b1,
                       17'd197, ST_OK};
        script[13] = '{MODE_READ,   17'd0,      1'b0, 64'd0, 7'd1, 1'b1, 17'd1, ST_OK};
        script[14] = '{MODE_READ,   17'd64,     1'b0, 64'd0, 7'd1, 1'b1, 17'd0, ST_OK};
        script[15] = '{MODE_READ,   17'd196,    1'b1, 64'd0, 7'd1, 1'b0, 17'd0, ST_OK};
        script[16] = '{MODE_READ,   17'd197,    1'b0, 64'd0, 7'd1, 1'b1, 17'd0, ST_BAD};
        script[17] = '{MODE_RANK,   17'd63,     1'b1, 64'd0, 7'd1, 1'b1, 17'd64, ST_OK};
        script[18] = '{MODE_RANK,   17'd196,    1'b0, 64'd0, 7'd1, 1'b0, 17'd0, ST_OK};
        script[19] = '{MODE_RANK,   17'h1ffff,  1'b1, 64'd0, 7'd1, 1'b1, 17'd0, ST_BAD};
        script[20] = '{MODE_SELECT, 17'd64,     1'b1, 64'd0, 7'd1, 1'b1, 17'd63, ST_OK};
        script[21] = '{MODE_SELECT, 17'd1,      1'b0, 64'd0, 7'd1, 1'b1, 17'd64, ST_OK};
        script[22] = '{MODE_SELECT, 17'd0,      1'b0, 64'd0, 7'd1, 1'b1, 17'd0, ST_BAD};
        script[23] = '{MODE_SELECT, 17'h1ffff,  1'b1, 64'd0, 7'd1, 1'b1, 17'd0, ST_BAD};
        script[24] = '{MODE_SELECT, 17'd100,    1'b1, 64'd0, 7'd1, 1'b0, 17'd0, ST_OK};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[i])
            send_word(script[i]);

        // Random words in four idling phases.
        n = 0;
        while (n < 1030)
        begin
            case ((n / 260) % 4)
                0: begin send_pct = 0;  stall_pct = 0;  end
                1: begin send_pct = 66; stall_pct = 0;  end
                2: begin send_pct = 0;  stall_pct = 66; end
                default: begin send_pct = 31; stall_pct = 31; end
            endcase
            if (n == 300)
                hold_req = 1'b1;
            if (n == 700)
            begin
                push <= 1'b0;
                while (answers_due.size() != 0)
                    @(negedge clk);
            end
            s = random_step();
            send_word(s);
            n++;
        end
        push <= 1'b0;

        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0 && answers_due.size() == 0)
            $display("rank_select_bit_vector: match");
        else
            $display("rank_select_bit_vector: mismatch");
        $finish;
    end
endmodule
